### sv/assert_macros.svh
// Assertion macros, included by the cipher top level to check its own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### sv/aes_pkg.sv
// Shared types, constants and helper functions of the AES-256 counter mode block.
package aes_pkg;

   localparam int NUM_ROUNDS = 14;
   localparam int CSR_ADDR_W = 6;

   typedef logic [3:0] round_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXPAND,
      ST_ENCRYPT,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      REG_KEY_WORD_0 = 3'd0,
      REG_KEY_WORD_1 = 3'd1,
      REG_KEY_WORD_2 = 3'd2,
      REG_KEY_WORD_3 = 3'd3,
      REG_NONCE_HIGH = 3'd4,
      REG_NONCE_LOW  = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [255:0] key;
      logic [95:0]  nonce;
   } cfg_type;

   localparam round_type LAST_ROUND = round_type'(NUM_ROUNDS);

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   localparam logic [7:0] RCON [8] = '{
      8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40
   };

   // Multiplication by two in the AES field.
   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // Byte i of a block, byte 0 in the top bits.
   function automatic logic [7:0] get_byte(input logic [127:0] blk, input int i);
      return blk[127 - 8 * i -: 8];
   endfunction

endpackage

### sv/aes_ifs.sv
// Valid/ready channel interfaces for the request and response beats.
interface aes_req_if;
   logic        valid;
   logic        ready;
   logic        first_block;
   logic [63:0] data_hi;
   logic [63:0] data_lo;
   logic [4:0]  byte_count;

   modport source(output valid, first_block, data_hi, data_lo, byte_count, input ready);
   modport sink(input valid, first_block, data_hi, data_lo, byte_count, output ready);
endinterface

interface aes_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] out_hi;
   logic [63:0] out_lo;
   logic [4:0]  out_count;

   modport source(output valid, out_hi, out_lo, out_count, input ready);
   modport sink(input valid, out_hi, out_lo, out_count, output ready);
endinterface

### sv/aes256_ctr_cipher.sv
// Top level of the AES-256 counter mode cipher.
//
// Usage: key and nonce are written through the APB-style port (register i at
// byte address 8*i) while the block is idle. Each request beat carries one
// 16-byte block, its valid byte count and a first-block flag; each beat
// produces exactly one response beat with the XORed block, bytes past the
// count cleared, and the count copied.
// A beat with the first-block flag set first runs the key schedule, one round
// key per cycle from a single key step unit, and restarts the block counter
// at one. The block is then encrypted by one shared round unit, one round per
// cycle with the initial key addition included, and the result is then moved
// into the output register once that register is free. The next request is
// taken only once the result has been moved to the output register, so no new
// beat is taken while one is still in work.
// Reset clears the controller, the round count, the response valid flag, the
// counter (to one) and the key and nonce registers; round keys are only valid
// after a first block. If the receiver stalls, the finished result waits in
// the output register; a second result waits in the round register until the
// output register drains.
`include "assert_macros.svh"

module aes256_ctr_cipher (
   input  logic                           clock,
   input  logic                           reset,
   aes_req_if.sink                        req_bus,
   aes_rsp_if.source                      rsp_bus,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [aes_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [63:0]                    pwdata,
   output logic [63:0]                    prdata,
   output logic                           pready
);

   aes_pkg::cfg_type   cfg;
   aes_pkg::state_type state_ff, state_in;
   aes_pkg::round_type round_ff, round_in;
   logic [127:0] blk_ff, blk_in;
   logic [127:0] ctr_blk_ff, ctr_blk_in;
   logic [127:0] data_ff, data_in;
   logic [4:0]   count_ff, count_in;
   logic [255:0] window_ff, window_in;
   logic [31:0]  counter_ff, counter_in;
   logic [31:0]  counter_now;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [63:0]  out_hi_ff, out_hi_in, out_lo_ff, out_lo_in;
   logic [4:0]   out_count_ff, out_count_in;
   logic [127:0] rk_ff [aes_pkg::NUM_ROUNDS + 1];
   logic [127:0] rk_rd;
   logic [127:0] new_key;
   logic [127:0] round_res;
   logic [127:0] masked;
   logic         rk_we;
   logic         accept;
   logic         slot_free;

   aes_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   aes_keyexp u_keyexp (
      .window  (window_ff),
      .round   (round_ff),
      .key_out (new_key)
   );

   aes_round u_round (
      .blk  (blk_ff),
      .last (round_ff == aes_pkg::LAST_ROUND),
      .res  (round_res)
   );

   assign req_bus.ready = (state_ff == aes_pkg::ST_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;
   assign slot_free     = !rsp_valid_ff || rsp_bus.ready;
   assign counter_now   = req_bus.first_block ? 32'd1 : counter_ff;
   assign rk_rd         = rk_ff[round_ff];

   // Keystream XOR with every byte at or past the count cleared.
   always_comb begin
      for (int i = 0; i < 16; i++) begin
         if (5'(i) < count_ff) begin
            masked[127 - 8 * i -: 8] = data_ff[127 - 8 * i -: 8] ^ blk_ff[127 - 8 * i -: 8];
         end else begin
            masked[127 - 8 * i -: 8] = 8'h00;
         end
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         aes_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = req_bus.first_block ? aes_pkg::ST_EXPAND : aes_pkg::ST_ENCRYPT;
            end
         end
         aes_pkg::ST_EXPAND: begin
            if (round_ff == aes_pkg::LAST_ROUND) begin
               state_in = aes_pkg::ST_ENCRYPT;
            end
         end
         aes_pkg::ST_ENCRYPT: begin
            if (round_ff == aes_pkg::LAST_ROUND) begin
               state_in = aes_pkg::ST_DONE;
            end
         end
         aes_pkg::ST_DONE: begin
            if (slot_free) begin
               state_in = aes_pkg::ST_IDLE;
            end
         end
         default: state_in = aes_pkg::ST_IDLE;
      endcase
   end

   // Datapath and outputs for each state.
   always_comb begin
      round_in     = round_ff;
      blk_in       = blk_ff;
      ctr_blk_in   = ctr_blk_ff;
      data_in      = data_ff;
      count_in     = count_ff;
      window_in    = window_ff;
      counter_in   = counter_ff;
      rk_we        = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      out_hi_in    = out_hi_ff;
      out_lo_in    = out_lo_ff;
      out_count_in = out_count_ff;
      case (state_ff)
         aes_pkg::ST_IDLE: begin
            if (accept) begin
               data_in    = {req_bus.data_hi, req_bus.data_lo};
               count_in   = req_bus.byte_count;
               ctr_blk_in = {cfg.nonce, counter_now};
               counter_in = counter_now + 32'd1;
               window_in  = cfg.key;
               round_in   = '0;
            end
         end
         aes_pkg::ST_EXPAND: begin
            rk_we = 1'b1;
            if (round_ff >= 4'd2) begin
               window_in = {window_ff[127:0], new_key};
            end
            round_in = (round_ff == aes_pkg::LAST_ROUND) ? '0 : round_ff + 4'd1;
         end
         aes_pkg::ST_ENCRYPT: begin
            if (round_ff == '0) begin
               blk_in = ctr_blk_ff ^ rk_rd;
            end else begin
               blk_in = round_res ^ rk_rd;
            end
            round_in = (round_ff == aes_pkg::LAST_ROUND) ? '0 : round_ff + 4'd1;
         end
         aes_pkg::ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               out_hi_in    = masked[127:64];
               out_lo_in    = masked[63:0];
               out_count_in = count_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= aes_pkg::ST_IDLE;
         round_ff     <= '0;
         counter_ff   <= 32'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         round_ff     <= round_in;
         counter_ff   <= counter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff       <= blk_in;
      ctr_blk_ff   <= ctr_blk_in;
      data_ff      <= data_in;
      count_ff     <= count_in;
      window_ff    <= window_in;
      out_hi_ff    <= out_hi_in;
      out_lo_ff    <= out_lo_in;
      out_count_ff <= out_count_in;
      if (rk_we) begin
         rk_ff[round_ff] <= new_key;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.out_hi    = out_hi_ff;
   assign rsp_bus.out_lo    = out_lo_ff;
   assign rsp_bus.out_count = out_count_ff;

   `ASSERT_NEXT(a_accept_starts, clock, reset, accept, state_ff != aes_pkg::ST_IDLE, "accepted beat did not start work")
   `ASSERT_NEXT(a_first_counter, clock, reset, accept && req_bus.first_block, counter_ff == 32'd2, "counter did not restart on first block")
   `ASSERT_NEXT(a_rsp_from_done, clock, reset, !rsp_valid_ff, !rsp_valid_ff || $past(state_ff) == aes_pkg::ST_DONE, "response raised outside the final state")
   `ASSERT_IMPLIES(a_round_range, clock, reset, state_ff != aes_pkg::ST_IDLE, round_ff <= aes_pkg::LAST_ROUND, "round counter past last round")

endmodule

### sv/aes_csr.sv
// Configuration register file holding the key and the nonce.
module aes_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [aes_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [63:0]                    pwdata,
   output logic [63:0]                    prdata,
   output logic                           pready,
   output aes_pkg::cfg_type               cfg
);

   logic [63:0] key0_ff, key1_ff, key2_ff, key3_ff, nonce_hi_ff;
   logic [31:0] nonce_lo_ff;
   logic        wr_en;
   logic [2:0]  index;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign index  = paddr[5:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         key0_ff     <= '0;
         key1_ff     <= '0;
         key2_ff     <= '0;
         key3_ff     <= '0;
         nonce_hi_ff <= '0;
         nonce_lo_ff <= '0;
      end else if (wr_en) begin
         case (index)
            aes_pkg::REG_KEY_WORD_0: key0_ff     <= pwdata;
            aes_pkg::REG_KEY_WORD_1: key1_ff     <= pwdata;
            aes_pkg::REG_KEY_WORD_2: key2_ff     <= pwdata;
            aes_pkg::REG_KEY_WORD_3: key3_ff     <= pwdata;
            aes_pkg::REG_NONCE_HIGH: nonce_hi_ff <= pwdata;
            aes_pkg::REG_NONCE_LOW:  nonce_lo_ff <= pwdata[31:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         aes_pkg::REG_KEY_WORD_0: prdata = key0_ff;
         aes_pkg::REG_KEY_WORD_1: prdata = key1_ff;
         aes_pkg::REG_KEY_WORD_2: prdata = key2_ff;
         aes_pkg::REG_KEY_WORD_3: prdata = key3_ff;
         aes_pkg::REG_NONCE_HIGH: prdata = nonce_hi_ff;
         aes_pkg::REG_NONCE_LOW:  prdata = {32'h0, nonce_lo_ff};
         default:                 prdata = '0;
      endcase
   end

   assign cfg.key   = {key0_ff, key1_ff, key2_ff, key3_ff};
   assign cfg.nonce = {nonce_hi_ff, nonce_lo_ff};

endmodule

### sv/aes_keyexp.sv
// One step of the AES-256 key schedule: produces round key r from the last two, or a key half for rounds 0 and 1.
module aes_keyexp (
   input  logic [255:0]        window,
   input  aes_pkg::round_type  round,
   output logic [127:0]        key_out
);

   logic [31:0] prev;
   logic [31:0] t;
   logic [31:0] w0, w1, w2, w3;

   assign prev = window[31:0];

   always_comb begin
      if (round[0] == 1'b0) begin
         // Even round keys start with rotate, substitute and round constant.
         t = {aes_pkg::SBOX[prev[23:16]] ^ aes_pkg::RCON[round[3:1]],
              aes_pkg::SBOX[prev[15:8]],
              aes_pkg::SBOX[prev[7:0]],
              aes_pkg::SBOX[prev[31:24]]};
      end else begin
         t = {aes_pkg::SBOX[prev[31:24]], aes_pkg::SBOX[prev[23:16]],
              aes_pkg::SBOX[prev[15:8]], aes_pkg::SBOX[prev[7:0]]};
      end
   end

   assign w0 = t  ^ window[255:224];
   assign w1 = w0 ^ window[223:192];
   assign w2 = w1 ^ window[191:160];
   assign w3 = w2 ^ window[159:128];

   always_comb begin
      case (round)
         4'd0:    key_out = window[255:128];
         4'd1:    key_out = window[127:0];
         default: key_out = {w0, w1, w2, w3};
      endcase
   end

endmodule

### sv/aes_round.sv
// One AES encryption round without the key addition.
module aes_round (
   input  logic [127:0] blk,
   input  logic         last,
   output logic [127:0] res
);

   always_comb begin
      logic [7:0] tmp [16];
      logic [7:0] a0, a1, a2, a3, all;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            tmp[c * 4 + r] = aes_pkg::SBOX[aes_pkg::get_byte(blk, ((c + r) % 4) * 4 + r)];
         end
      end
      for (int c = 0; c < 4; c++) begin
         a0  = tmp[c * 4];
         a1  = tmp[c * 4 + 1];
         a2  = tmp[c * 4 + 2];
         a3  = tmp[c * 4 + 3];
         all = a0 ^ a1 ^ a2 ^ a3;
         if (last) begin
            res[127 - 32 * c -: 32] = {a0, a1, a2, a3};
         end else begin
            res[127 - 32 * c -: 32] = {a0 ^ all ^ aes_pkg::xtime(a0 ^ a1),
                                       a1 ^ all ^ aes_pkg::xtime(a1 ^ a2),
                                       a2 ^ all ^ aes_pkg::xtime(a2 ^ a3),
                                       a3 ^ all ^ aes_pkg::xtime(a3 ^ a0)};
         end
      end
   end

endmodule
